// ===== rtl/vafs_pkg.sv =====
package vafs_pkg;

  localparam int SrcW       = 8;
  localparam int LvlW       = 16;
  localparam int NumSources = 256;
  localparam int NumSlots   = 32;
  localparam int SlotW      = 5;
  localparam int SlotFieldW = 6;
  localparam int OwnerW     = 9;
  localparam int ActW       = 3;
  localparam int CountW     = 6;

  localparam logic [SlotFieldW-1:0] SlotNone   = 6'h20;
  localparam logic [OwnerW-1:0]     OwnerEmpty = 9'h100;
  localparam logic [CountW-1:0]     SlotsMax   = 6'd32;
  localparam logic [LvlW:0]         LevelAboveFull = 17'h10000;

  localparam logic [ActW-1:0] ACT_NONE    = 3'd0;
  localparam logic [ActW-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ActW-1:0] ACT_UPDATE  = 3'd2;
  localparam logic [ActW-1:0] ACT_TAKE    = 3'd3;
  localparam logic [ActW-1:0] ACT_STEAL   = 3'd4;

  localparam logic [2:0] KIND_NOP     = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_UPDATE  = 3'd2;
  localparam logic [2:0] KIND_FREE    = 3'd3;
  localparam logic [2:0] KIND_STEAL   = 3'd4;

  typedef struct packed {
    logic [SlotFieldW-1:0] slot;
    logic [LvlW-1:0]       level;
  } row_t;

  localparam int RowW = SlotFieldW + LvlW;

  typedef struct packed {
    logic accept;
    logic simple;
    logic free_scan;
    logic faint_issue;
    logic faint_cmp;
    logic steal_evict;
    logic steal_bind;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       n_zero;
    logic       free_hit;
    logic       scan_last;
    logic       steal_ok;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/vafs_ram.sv =====
module vafs_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vafs_ctrl.sv =====
module vafs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  vafs_pkg::sts_t  sts,
  output vafs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_FISS  = 3'd3;
  localparam logic [2:0] S_FLAST = 3'd4;
  localparam logic [2:0] S_STEAL = 3'd5;
  localparam logic [2:0] S_WSRC  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        case (sts.kind)
          vafs_pkg::KIND_FREE: state_nxt = S_FREE;
          vafs_pkg::KIND_STEAL: state_nxt = sts.n_zero ? S_STEAL : S_FISS;
          default: begin
            cmd.simple = 1'b1;
            state_nxt  = S_OUT;
          end
        endcase
      end
      S_FREE: begin
        cmd.free_scan = 1'b1;
        if (sts.free_hit || sts.scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_FISS: begin
        cmd.faint_issue = 1'b1;
        cmd.faint_cmp   = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FLAST;
        end
      end
      S_FLAST: begin
        cmd.faint_cmp = 1'b1;
        state_nxt     = S_STEAL;
      end
      S_STEAL: begin
        cmd.steal_evict = 1'b1;
        state_nxt       = sts.steal_ok ? S_WSRC : S_OUT;
      end
      S_WSRC: begin
        cmd.steal_bind = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/vafs_dp.sv =====
module vafs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wen,
  input  logic [vafs_pkg::CountW-1:0]  cfg_wdata,
  input  logic [vafs_pkg::SrcW-1:0]    in_source_id,
  input  logic [vafs_pkg::LvlW-1:0]    in_audibility,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [vafs_pkg::ActW-1:0]    out_action,
  output logic [vafs_pkg::SlotW-1:0]   out_slot_index,
  output logic [vafs_pkg::SrcW-1:0]    out_evicted_source,
  output logic [vafs_pkg::SrcW-1:0]    out_echo_source,
  input  vafs_pkg::cmd_t               cmd,
  output vafs_pkg::sts_t               sts
);

  logic [vafs_pkg::CountW-1:0] active_r;
  logic [vafs_pkg::CountW-1:0] count_r;
  logic [vafs_pkg::OwnerW-1:0] owner_r [vafs_pkg::NumSlots];
  logic [vafs_pkg::NumSources-1:0] valid_r;
  logic                        rd_valid_r;

  logic [vafs_pkg::SrcW-1:0]   src_r;
  logic [vafs_pkg::LvlW-1:0]   lvl_r;
  logic [vafs_pkg::SlotW-1:0]  idx_r;
  logic                        pend_r;
  logic [vafs_pkg::OwnerW-1:0] powner_r;
  logic [vafs_pkg::SlotW-1:0]  pidx_r;
  logic [vafs_pkg::LvlW:0]     faint_r;
  logic [vafs_pkg::SlotW-1:0]  pick_r;
  logic [vafs_pkg::SrcW-1:0]   pick_owner_r;

  logic [vafs_pkg::ActW-1:0]   res_action_r;
  logic [vafs_pkg::SlotW-1:0]  res_slot_r;
  logic [vafs_pkg::SrcW-1:0]   res_evict_r;

  logic                        out_valid_r;
  logic [vafs_pkg::ActW-1:0]   out_action_r;
  logic [vafs_pkg::SlotW-1:0]  out_slot_r;
  logic [vafs_pkg::SrcW-1:0]   out_evict_r;
  logic [vafs_pkg::SrcW-1:0]   out_echo_r;

  logic [vafs_pkg::CountW-1:0] usable;
  logic [vafs_pkg::RowW-1:0]   rdata;
  vafs_pkg::row_t              row_rd;
  logic [vafs_pkg::SlotFieldW-1:0] cur_slot;
  logic [vafs_pkg::LvlW-1:0]   cur_level;
  logic                        held;

  logic                        ram_we;
  logic [vafs_pkg::SrcW-1:0]   ram_waddr;
  vafs_pkg::row_t              ram_wrow;
  logic                        ram_re;
  logic [vafs_pkg::SrcW-1:0]   ram_raddr;
  logic [vafs_pkg::OwnerW-1:0] owner_at_idx;

  assign usable       = (active_r > vafs_pkg::SlotsMax) ? vafs_pkg::SlotsMax : active_r;
  assign row_rd       = vafs_pkg::row_t'(rdata);
  assign cur_slot     = rd_valid_r ? row_rd.slot : vafs_pkg::SlotNone;
  assign cur_level    = rd_valid_r ? row_rd.level : '0;
  assign held         = !cur_slot[vafs_pkg::SlotFieldW-1];
  assign owner_at_idx = owner_r[idx_r];

  always_comb begin
    sts.n_zero    = (usable == '0);
    sts.free_hit  = owner_at_idx[vafs_pkg::OwnerW-1];
    sts.scan_last = ({1'b0, idx_r} == (usable - 6'd1));
    sts.steal_ok  = (faint_r < {1'b0, lvl_r});
    sts.out_free  = !out_valid_r || out_tready;
    if (lvl_r == '0) begin
      sts.kind = held ? vafs_pkg::KIND_RELEASE : vafs_pkg::KIND_NOP;
    end else if (held) begin
      sts.kind = vafs_pkg::KIND_UPDATE;
    end else if (count_r < usable) begin
      sts.kind = vafs_pkg::KIND_FREE;
    end else begin
      sts.kind = vafs_pkg::KIND_STEAL;
    end
  end

  assign ram_re    = cmd.accept || cmd.faint_issue;
  assign ram_raddr = cmd.accept ? in_source_id : owner_at_idx[vafs_pkg::SrcW-1:0];

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = src_r;
    ram_wrow.slot  = vafs_pkg::SlotNone;
    ram_wrow.level = lvl_r;
    if (cmd.simple) begin
      ram_we = 1'b1;
      if (lvl_r != '0) begin
        ram_wrow.slot = cur_slot;
      end
    end
    if (cmd.free_scan && (sts.free_hit || sts.scan_last)) begin
      ram_we = 1'b1;
      if (sts.free_hit) begin
        ram_wrow.slot = {1'b0, idx_r};
      end
    end
    if (cmd.steal_evict) begin
      ram_we = 1'b1;
      if (sts.steal_ok) begin
        ram_waddr      = pick_owner_r;
        ram_wrow.level = faint_r[vafs_pkg::LvlW-1:0];
      end
    end
    if (cmd.steal_bind) begin
      ram_we        = 1'b1;
      ram_wrow.slot = {1'b0, pick_r};
    end
  end

  vafs_ram #(
    .WIDTH (vafs_pkg::RowW),
    .DEPTH (vafs_pkg::NumSources)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrow),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= vafs_pkg::SlotsMax;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < vafs_pkg::NumSlots; i++) begin
        owner_r[i] <= vafs_pkg::OwnerEmpty;
      end
    end else begin
      if (cfg_wen) begin
        active_r <= cfg_wdata;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cmd.simple && (sts.kind == vafs_pkg::KIND_RELEASE)) begin
        owner_r[cur_slot[vafs_pkg::SlotW-1:0]] <= vafs_pkg::OwnerEmpty;
        if (count_r != '0) begin
          count_r <= count_r - 6'd1;
        end
      end
      if (cmd.free_scan && sts.free_hit) begin
        owner_r[idx_r] <= {1'b0, src_r};
        count_r        <= count_r + 6'd1;
      end
      if (cmd.steal_evict && sts.steal_ok) begin
        owner_r[pick_r] <= {1'b0, src_r};
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
    end
    if (cmd.accept) begin
      src_r        <= in_source_id;
      lvl_r        <= in_audibility;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      faint_r      <= vafs_pkg::LevelAboveFull;
      pick_r       <= '0;
      pick_owner_r <= '0;
      res_action_r <= vafs_pkg::ACT_NONE;
      res_slot_r   <= '0;
      res_evict_r  <= '0;
    end
    if (cmd.simple) begin
      if (sts.kind == vafs_pkg::KIND_RELEASE) begin
        res_action_r <= vafs_pkg::ACT_RELEASE;
        res_slot_r   <= cur_slot[vafs_pkg::SlotW-1:0];
      end else if (sts.kind == vafs_pkg::KIND_UPDATE) begin
        res_action_r <= vafs_pkg::ACT_UPDATE;
        res_slot_r   <= cur_slot[vafs_pkg::SlotW-1:0];
      end
    end
    if (cmd.free_scan) begin
      if (sts.free_hit) begin
        res_action_r <= vafs_pkg::ACT_TAKE;
        res_slot_r   <= idx_r;
      end else begin
        idx_r <= idx_r + 5'd1;
      end
    end
    if (cmd.faint_cmp && pend_r && !powner_r[vafs_pkg::OwnerW-1]
        && ({1'b0, cur_level} < faint_r)) begin
      faint_r      <= {1'b0, cur_level};
      pick_r       <= pidx_r;
      pick_owner_r <= powner_r[vafs_pkg::SrcW-1:0];
    end
    if (cmd.faint_issue) begin
      pend_r   <= 1'b1;
      powner_r <= owner_at_idx;
      pidx_r   <= idx_r;
      idx_r    <= idx_r + 5'd1;
    end
    if (cmd.steal_bind) begin
      res_action_r <= vafs_pkg::ACT_STEAL;
      res_slot_r   <= pick_r;
      res_evict_r  <= pick_owner_r;
    end
    if (cmd.out_load) begin
      out_action_r <= res_action_r;
      out_slot_r   <= res_slot_r;
      out_evict_r  <= res_evict_r;
      out_echo_r   <= src_r;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_action         = out_action_r;
  assign out_slot_index     = out_slot_r;
  assign out_evicted_source = out_evict_r;
  assign out_echo_source    = out_echo_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vafs_pkg::SlotsMax)
    else $error("slot count exceeds pool size");

  a_steal_louder: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.steal_bind |-> (faint_r[vafs_pkg::LvlW] == 1'b0) && (faint_r < {1'b0, lvl_r}))
    else $error("steal without a fainter holder");

  a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.simple && (sts.kind == vafs_pkg::KIND_RELEASE)) |-> (count_r != '0))
    else $error("release with no slot in use");

  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.free_scan && sts.free_hit) |=> (count_r == $past(count_r) + 6'd1))
    else $error("slot count not raised on take");

endmodule

// ===== rtl/voice_allocator_steal_faintest_top.sv =====
// Voice allocator: maps virtual sound sources onto a pool of 32 playback slots.
// Input channel (in_*): one transfer per audibility change, source and level.
// Output channel (out_*): exactly one result transfer per input transfer, in order,
// giving the action taken, the slot concerned, the evicted source and the echoed source.
// Configuration: cfg_wen writes cfg_wdata into the active slot count; write it only
// while no input is in flight.
// A release, update or no-op needs no search. Taking a free slot scans the slot table
// one entry per cycle, stopping at the first empty slot or after the last usable slot.
// The faintest search reads the owner row of every usable slot through the source table
// read port and compares each returned level; a steal takes the slot only when the
// newcomer is louder, and no search is made when the usable slot count is zero.
// One input is processed at a time; in_tready is high only between items.
// After reset all sources are silent and slotless, every slot is empty and the
// active slot count is 32; no clearing pass is needed.
// If the receiver stalls, the result holds in the output register and the next
// input is still accepted; its result waits until the earlier one is taken.
module voice_allocator_steal_faintest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] source_id, [23:8] audibility
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] action, [7:3] slot_index,
                                  // [15:8] evicted_source, [23:16] echo_source
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata
);

  vafs_pkg::cmd_t cmd;
  vafs_pkg::sts_t sts;

  logic [vafs_pkg::ActW-1:0]  out_action;
  logic [vafs_pkg::SlotW-1:0] out_slot_index;
  logic [vafs_pkg::SrcW-1:0]  out_evicted_source;
  logic [vafs_pkg::SrcW-1:0]  out_echo_source;

  vafs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vafs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .in_source_id       (in_tdata[7:0]),
    .in_audibility      (in_tdata[23:8]),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_action         (out_action),
    .out_slot_index     (out_slot_index),
    .out_evicted_source (out_evicted_source),
    .out_echo_source    (out_echo_source),
    .cmd                (cmd),
    .sts                (sts)
  );

  assign out_tdata = {out_echo_source, out_evicted_source, out_slot_index, out_action};

endmodule
